FILE: rtl/rqf_pkg.sv
// ----------------------------------------------------------------------------
// rqf_pkg
// Shared types, codes and constants of the read quality filter and splitter.
// ----------------------------------------------------------------------------
package rqf_pkg;

    // Default sizes
    localparam int MAX_READ_LEN_DEF  = 256;
    localparam int MAX_FRAGMENTS_DEF = 16;

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int PCT_W   = 7;
    localparam int START_W = 8;
    localparam int LEN_W   = 9;
    localparam int ENTRY_W = START_W + LEN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Number of fragment table banks and depth of the read descriptor queue
    localparam int BANKS      = 2;
    localparam int DESC_DEPTH = 2;

    // Register reset values
    localparam logic [CHAR_W-1:0] QUAL_THR_RST  = 8'd53;
    localparam logic [PCT_W-1:0]  LOW_PCT_RST   = 7'd10;
    localparam logic [CHAR_W-1:0] MIN_LEN_RST   = 8'd30;
    localparam logic [CHAR_W-1:0] SPLIT_SYM_RST = 8'd78;

    // Quality compare scale
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAL_THR  = 2'd0,
        CFG_LOW_PCT   = 2'd1,
        CFG_MIN_LEN   = 2'd2,
        CFG_SPLIT_SYM = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_REJECT_QUAL = 2'd0,
        ST_ACCEPT      = 2'd1,
        ST_TOO_LONG    = 2'd2
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] qual_thr;
        logic [PCT_W-1:0]  low_pct;
        logic [CHAR_W-1:0] min_len;
        logic [CHAR_W-1:0] split_sym;
    } t_cfg;

    // Per-read summary handed from the front to the back
    typedef struct packed {
        t_status status;
        logic    overflow;
        logic    bank;
    } t_read_info;

endpackage

FILE: rtl/rqf_base_if.sv
// ----------------------------------------------------------------------------
// rqf_base_if
// Valid/ready channel carrying one base and its quality character.
// ----------------------------------------------------------------------------
interface rqf_base_if;
    logic                        valid;
    logic                        ready;
    logic [rqf_pkg::CHAR_W-1:0]  base_char;
    logic [rqf_pkg::CHAR_W-1:0]  quality_char;
    logic                        end_of_read;

    modport source (output valid, base_char, quality_char, end_of_read, input ready);
    modport sink   (input valid, base_char, quality_char, end_of_read, output ready);
endinterface

FILE: rtl/rqf_result_if.sv
// ----------------------------------------------------------------------------
// rqf_result_if
// Valid/ready channel carrying one read status or fragment descriptor.
// ----------------------------------------------------------------------------
interface rqf_result_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  read_status;
    logic                        fragment_valid;
    logic [rqf_pkg::START_W-1:0] fragment_start;
    logic [rqf_pkg::LEN_W-1:0]   fragment_length;
    logic                        fragment_overflow;
    logic                        last_result;

    modport source (output valid, read_status, fragment_valid, fragment_start,
                    fragment_length, fragment_overflow, last_result, input ready);
    modport sink   (input valid, read_status, fragment_valid, fragment_start,
                    fragment_length, fragment_overflow, last_result, output ready);
endinterface

FILE: rtl/rqf_ram.sv
// ----------------------------------------------------------------------------
// rqf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: rtl/rqf_front.sv
// ----------------------------------------------------------------------------
// rqf_front
// Base intake: counts low-quality bases, finds split-free runs, stores
// fragments into the current table bank and summarizes each finished read.
// ----------------------------------------------------------------------------
module rqf_front #(
    parameter int MAX_READ_LEN  = rqf_pkg::MAX_READ_LEN_DEF,
    parameter int MAX_FRAGMENTS = rqf_pkg::MAX_FRAGMENTS_DEF,
    localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1),
    localparam int IDX_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
    localparam int ADDR_W = IDX_W + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rqf_base_if.sink                     i_base,
    input  rqf_pkg::t_cfg                i_cfg,
    input  logic                         i_blocked,
    output logic                         o_push,
    output rqf_pkg::t_read_info          o_info,
    output logic [CNT_W-1:0]             o_count,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [rqf_pkg::ENTRY_W-1:0]  o_wr_data
);
    import rqf_pkg::*;

    localparam int POS_W  = $clog2(MAX_READ_LEN + 1);
    localparam int EXT_W  = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int PROD_W = POS_W + PCT_W;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_run_start;
    logic [POS_W-1:0] r_low;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_too_long;
    logic             r_bank;
    logic             r_finish;

    logic              w_acc;
    logic              w_in_range;
    logic              w_close;
    logic [POS_W-1:0]  w_len;
    logic [EXT_W-1:0]  w_len_ext;
    logic [EXT_W-1:0]  w_start_ext;
    logic              w_keep;
    logic              w_room;
    logic              w_store;
    logic              w_ovf_set;
    logic [PROD_W-1:0] w_low_scaled;
    logic [PROD_W-1:0] w_len_scaled;
    t_status           w_status;

    // Take a base unless closing a read or both table banks are in use
    assign i_base.ready = !r_finish && !i_blocked;
    assign w_acc        = i_base.valid && i_base.ready;
    assign w_in_range   = r_pos < POS_W'(MAX_READ_LEN);

    // Close a run on a split base, or at read end for a read within bounds
    assign w_close = (w_acc && w_in_range && (i_base.base_char == i_cfg.split_sym))
                   || (r_finish && !r_too_long);
    assign w_len       = r_pos - r_run_start;
    assign w_len_ext   = EXT_W'(w_len);
    assign w_start_ext = EXT_W'(r_run_start);
    assign w_keep      = w_close && (w_len_ext >= EXT_W'(i_cfg.min_len));
    assign w_room      = r_cnt < CNT_W'(MAX_FRAGMENTS);
    assign w_store     = w_keep && w_room;
    assign w_ovf_set   = w_keep && !w_room;

    // Store the fragment in the current bank
    assign o_wr_en   = w_store;
    assign o_wr_addr = {r_bank, r_cnt[IDX_W-1:0]};
    assign o_wr_data = {w_start_ext[START_W-1:0], w_len_ext[LEN_W-1:0]};

    // Reject when 100 * low > percent * length
    assign w_low_scaled = PROD_W'(r_low) * PROD_W'(PCT_SCALE);
    assign w_len_scaled = PROD_W'(i_cfg.low_pct) * PROD_W'(r_pos);

    always_comb begin
        if (r_too_long) begin
            w_status = ST_TOO_LONG;
        end else if (w_low_scaled > w_len_scaled) begin
            w_status = ST_REJECT_QUAL;
        end else begin
            w_status = ST_ACCEPT;
        end
    end

    // Hand the read summary to the queue in the closing cycle
    assign o_push          = r_finish;
    assign o_info.status   = w_status;
    assign o_info.overflow = r_ovf || w_ovf_set;
    assign o_info.bank     = r_bank;
    assign o_count         = r_cnt + CNT_W'(w_store);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_run_start <= '0;
            r_low       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_too_long  <= 1'b0;
            r_bank      <= 1'b0;
            r_finish    <= 1'b0;
        end else if (r_finish) begin
            // Clear per-read state and flip to the other bank
            r_pos       <= '0;
            r_run_start <= '0;
            r_low       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_too_long  <= 1'b0;
            r_bank      <= !r_bank;
            r_finish    <= 1'b0;
        end else if (w_acc) begin
            if (w_in_range) begin
                if (i_base.quality_char < i_cfg.qual_thr) begin
                    r_low <= r_low + 1'b1;
                end
                if (i_base.base_char == i_cfg.split_sym) begin
                    r_run_start <= r_pos + 1'b1;
                end
                r_pos <= r_pos + 1'b1;
            end else begin
                r_too_long <= 1'b1;
            end
            r_cnt    <= r_cnt + CNT_W'(w_store);
            r_ovf    <= r_ovf || w_ovf_set;
            r_finish <= i_base.end_of_read;
        end
    end

endmodule

FILE: rtl/rqf_fifo.sv
// ----------------------------------------------------------------------------
// rqf_fifo
// Short first-word-fall-through queue of finished read descriptors.
// ----------------------------------------------------------------------------
module rqf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rqf_pkg::DESC_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_data  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

FILE: rtl/rqf_back.sv
// ----------------------------------------------------------------------------
// rqf_back
// Result emitter: takes one read descriptor at a time and sends either its
// status result or its fragment descriptors read back from the table bank.
// ----------------------------------------------------------------------------
module rqf_back #(
    parameter int MAX_FRAGMENTS = rqf_pkg::MAX_FRAGMENTS_DEF,
    localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1),
    localparam int IDX_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
    localparam int ADDR_W = IDX_W + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  rqf_pkg::t_read_info          i_info,
    input  logic [CNT_W-1:0]             i_count,
    output logic                         o_pop,
    output logic                         o_busy,
    output logic                         o_rd_en,
    output logic [ADDR_W-1:0]            o_rd_addr,
    input  logic [rqf_pkg::ENTRY_W-1:0]  i_rd_data,
    rqf_result_if.source                 o_result
);
    import rqf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STATUS,
        S_FETCH,
        S_DATA
    } t_state;

    t_state            r_state;
    t_read_info        r_info;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;

    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_frag;
    logic [START_W-1:0] r_out_start;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_ovf;
    logic               r_out_last;

    logic w_free;
    logic w_last_frag;
    logic w_load;

    assign w_free      = !r_out_valid || o_result.ready;
    assign w_last_frag = (CNT_W'(r_idx + 1'b1) == r_cnt);
    assign w_load      = ((r_state == S_STATUS) || (r_state == S_DATA)) && w_free;

    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign o_busy    = (r_state != S_IDLE);
    assign o_rd_en   = (r_state == S_FETCH);
    assign o_rd_addr = {r_info.bank, r_idx[IDX_W-1:0]};

    assign o_result.valid             = r_out_valid;
    assign o_result.read_status       = r_out_status;
    assign o_result.fragment_valid    = r_out_frag;
    assign o_result.fragment_start    = r_out_start;
    assign o_result.fragment_length   = r_out_len;
    assign o_result.fragment_overflow = r_out_ovf;
    assign o_result.last_result       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the output on a load, drop it once taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_info <= i_info;
                        r_cnt  <= i_count;
                        r_idx  <= '0;
                        if ((i_info.status == ST_ACCEPT) && (i_count != '0)) begin
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_STATUS;
                        end
                    end
                end
                S_STATUS: begin
                    // Send the single status transaction of the read
                    if (w_free) begin
                        r_out_status <= r_info.status;
                        r_out_frag   <= 1'b0;
                        r_out_start  <= '0;
                        r_out_len    <= '0;
                        r_out_ovf    <= r_info.overflow;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_FETCH: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    // Send one fragment transaction per table entry
                    if (w_free) begin
                        r_out_status <= ST_ACCEPT;
                        r_out_frag   <= 1'b1;
                        r_out_start  <= i_rd_data[ENTRY_W-1:LEN_W];
                        r_out_len    <= i_rd_data[LEN_W-1:0];
                        r_out_ovf    <= r_info.overflow;
                        r_out_last   <= w_last_frag;
                        r_idx        <= r_idx + 1'b1;
                        r_state      <= w_last_frag ? S_IDLE : S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/read_quality_filter_n_splitter.sv
// ----------------------------------------------------------------------------
// read_quality_filter_n_splitter
// Quality filter and split-symbol splitter for sequencing reads.
//
//   port       dir  transaction
//   i_base     in   one base: base_char, quality_char, end_of_read
//   o_result   out  one status or fragment descriptor of a finished read
//   i_cfg_*    in   register write: index, data (no read-back)
//
// Bases are taken while i_base.ready is high; after end_of_read, ready is
// low while the read closes (quality compare and final run close).
// Result loads never come back to back: a status result follows its
// descriptor pop, and each fragment follows its registered table RAM read.
// The table has two banks, so the next read streams in while the previous
// one is sent; intake stalls when two finished reads still wait for output.
// Synchronous active-low reset; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module read_quality_filter_n_splitter #(
    parameter int MAX_READ_LEN  = rqf_pkg::MAX_READ_LEN_DEF,
    parameter int MAX_FRAGMENTS = rqf_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rqf_base_if.sink                         i_base,
    rqf_result_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [rqf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rqf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rqf_pkg::*;

    localparam int CNT_W   = $clog2(MAX_FRAGMENTS + 1);
    localparam int IDX_W   = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int ADDR_W  = IDX_W + 1;
    localparam int DESC_W  = $bits(t_read_info) + CNT_W;
    localparam int QCNT_W  = $clog2(DESC_DEPTH + 1);
    localparam int PEND_W  = QCNT_W + 1;

    t_cfg r_cfg;

    logic               w_push;
    t_read_info         w_push_info;
    logic [CNT_W-1:0]   w_push_count;
    logic [DESC_W-1:0]  w_q_data;
    t_read_info         w_pop_info;
    logic [CNT_W-1:0]   w_pop_count;
    logic               w_q_empty;
    logic [QCNT_W-1:0]  w_q_count;
    logic               w_pop;
    logic               w_busy;
    logic [PEND_W-1:0]  w_pending;
    logic               w_blocked;

    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.qual_thr  <= QUAL_THR_RST;
            r_cfg.low_pct   <= LOW_PCT_RST;
            r_cfg.min_len   <= MIN_LEN_RST;
            r_cfg.split_sym <= SPLIT_SYM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_QUAL_THR:  r_cfg.qual_thr  <= i_cfg_data;
                CFG_LOW_PCT:   r_cfg.low_pct   <= i_cfg_data[PCT_W-1:0];
                CFG_MIN_LEN:   r_cfg.min_len   <= i_cfg_data;
                CFG_SPLIT_SYM: r_cfg.split_sym <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold intake while both table banks belong to unsent reads
    assign w_pending = PEND_W'(w_q_count) + PEND_W'(w_busy);
    assign w_blocked = w_pending >= PEND_W'(BANKS);

    rqf_front #(
        .MAX_READ_LEN  (MAX_READ_LEN),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_base    (i_base),
        .i_cfg     (r_cfg),
        .i_blocked (w_blocked),
        .o_push    (w_push),
        .o_info    (w_push_info),
        .o_count   (w_push_count),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    rqf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BANKS << IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    rqf_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (DESC_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_info, w_push_count}),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    assign w_pop_info  = t_read_info'(w_q_data[DESC_W-1:CNT_W]);
    assign w_pop_count = w_q_data[CNT_W-1:0];

    rqf_back #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!w_q_empty),
        .i_info    (w_pop_info),
        .i_count   (w_pop_count),
        .o_pop     (w_pop),
        .o_busy    (w_busy),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_result  (o_result)
    );

endmodule

FILE: rtl/rqf_checker.sv
// ----------------------------------------------------------------------------
// rqf_checker
// Port-level checks of the read quality filter and splitter.
// ----------------------------------------------------------------------------
module rqf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_eor,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic       i_frag_valid,
    input logic [7:0] i_frag_start,
    input logic [8:0] i_frag_len,
    input logic       i_frag_ovf,
    input logic       i_last
);
    import rqf_pkg::*;

    // The closing cycle of a read takes no base
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_eor |=> !i_in_ready)
        else $error("base taken in the read closing cycle");

    // No result is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A fragment descriptor only comes from an accepted read
    a_frag_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frag_valid |-> i_status == ST_ACCEPT)
        else $error("fragment on a rejected read");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_frag_valid) && $stable(i_frag_start)
            && $stable(i_frag_len) && $stable(i_frag_ovf) && $stable(i_last))
        else $error("stalled result changed");

endmodule

bind read_quality_filter_n_splitter rqf_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_base.valid),
    .i_in_ready   (i_base.ready),
    .i_in_eor     (i_base.end_of_read),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_status     (o_result.read_status),
    .i_frag_valid (o_result.fragment_valid),
    .i_frag_start (o_result.fragment_start),
    .i_frag_len   (o_result.fragment_length),
    .i_frag_ovf   (o_result.fragment_overflow),
    .i_last       (o_result.last_result)
);

FILE: sim/rqf_checker.sv
// ----------------------------------------------------------------------------
// rqf_tb_checker
// Watches the base, result and register write ports of the read quality
// filter, keeps its own model of the per-read state and the registers, and
// compares every accepted result, field by field, with the oldest one the
// model expects. Mismatches, results with nothing expected and counts for the
// run summary are handed to the testbench top.
// ----------------------------------------------------------------------------
module rqf_tb_checker #(
    parameter int MAX_READ_LEN  = rqf_pkg::MAX_READ_LEN_DEF,
    parameter int MAX_FRAGMENTS = rqf_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rqf_base_if                            i_base,
    rqf_result_if                          i_result,
    input  logic                           i_cfg_we,
    input  logic [rqf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rqf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output int                             o_reads,
    output int                             o_fragments,
    output int                             o_quality_rejects,
    output int                             o_overflow_reads
);
    import rqf_pkg::*;

    localparam int EXP_DEPTH = 256;

    typedef struct packed {
        t_status             status;
        logic                frag_valid;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    length;
        logic                overflow;
        logic                last;
    } t_read_result;

    // Register copies
    logic [CHAR_W-1:0] qual_thr;
    logic [PCT_W-1:0]  low_pct;
    logic [CHAR_W-1:0] min_len;
    logic [CHAR_W-1:0] split_sym;

    // Per-read state
    int unsigned base_pos;
    int unsigned run_begin;
    int unsigned low_count;
    int unsigned frag_count;
    bit          frag_overflow;
    bit          read_too_long;
    int unsigned frag_start_tab [MAX_FRAGMENTS];
    int unsigned frag_len_tab   [MAX_FRAGMENTS];

    // Expected results, oldest at the head
    t_read_result exp_ring [EXP_DEPTH];
    int unsigned  exp_head = 0;
    int unsigned  exp_tail = 0;

    int fail_cnt     = 0;
    int reads_cnt    = 0;
    int frags_cnt    = 0;
    int reject_cnt   = 0;
    int ovf_cnt      = 0;

    assign o_fail_count      = fail_cnt;
    assign o_reads           = reads_cnt;
    assign o_fragments       = frags_cnt;
    assign o_quality_rejects = reject_cnt;
    assign o_overflow_reads  = ovf_cnt;

    function automatic void clear_read();
        base_pos      = 0;
        run_begin     = 0;
        low_count     = 0;
        frag_count    = 0;
        frag_overflow = 1'b0;
        read_too_long = 1'b0;
    endfunction

    // Close the current split-free run; keep it if long enough and room is left
    function automatic void close_run();
        int unsigned run_len;
        run_len = base_pos - run_begin;
        if (run_len >= min_len) begin
            if (frag_count < MAX_FRAGMENTS) begin
                frag_start_tab[frag_count] = run_begin;
                frag_len_tab[frag_count]   = run_len;
                frag_count++;
            end else begin
                frag_overflow = 1'b1;
            end
        end
    endfunction

    function automatic void queue_result(t_status status, logic frag_valid,
                                         int unsigned start, int unsigned length,
                                         logic last);
        t_read_result r;
        r.status     = status;
        r.frag_valid = frag_valid;
        r.start      = start[START_W-1:0];
        r.length     = length[LEN_W-1:0];
        r.overflow   = frag_overflow;
        r.last       = last;
        if (exp_tail - exp_head >= EXP_DEPTH) begin
            fail_cnt++;
            $display("%0t: expected results overflow: expected below %0d, got %0d",
                     $time, EXP_DEPTH, exp_tail - exp_head);
            return;
        end
        exp_ring[exp_tail % EXP_DEPTH] = r;
        exp_tail++;
    endfunction

    // Fold one base into the read; on the last base work out the read's results
    function automatic void take_base(logic [CHAR_W-1:0] base_char,
                                      logic [CHAR_W-1:0] qual_char, logic eor);
        if (base_pos < MAX_READ_LEN) begin
            if (qual_char < qual_thr)
                low_count++;
            if (base_char == split_sym) begin
                close_run();
                run_begin = base_pos + 1;
            end
            base_pos++;
        end else begin
            read_too_long = 1'b1;
        end
        if (!eor)
            return;

        reads_cnt++;
        if (read_too_long) begin
            queue_result(ST_TOO_LONG, 1'b0, 0, 0, 1'b1);
        end else begin
            close_run();
            if (PCT_SCALE * low_count > low_pct * base_pos) begin
                queue_result(ST_REJECT_QUAL, 1'b0, 0, 0, 1'b1);
                reject_cnt++;
            end else if (frag_count == 0) begin
                queue_result(ST_ACCEPT, 1'b0, 0, 0, 1'b1);
            end else begin
                for (int i = 0; i < frag_count; i++)
                    queue_result(ST_ACCEPT, 1'b1, frag_start_tab[i], frag_len_tab[i],
                                 i + 1 == frag_count);
                frags_cnt += int'(frag_count);
            end
        end
        if (frag_overflow)
            ovf_cnt++;
        clear_read();
    endfunction

    function automatic void check_field(string name, logic [LEN_W-1:0] want,
                                        logic [LEN_W-1:0] got);
        if (got !== want) begin
            fail_cnt++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    function automatic void check_result();
        t_read_result want;
        if (exp_tail == exp_head) begin
            fail_cnt++;
            $display("%0t: unexpected result: expected none, got status %0d start %0d len %0d",
                     $time, i_result.read_status, i_result.fragment_start,
                     i_result.fragment_length);
            return;
        end
        want = exp_ring[exp_head % EXP_DEPTH];
        exp_head++;
        check_field("read_status",       LEN_W'(want.status),
                    LEN_W'(i_result.read_status));
        check_field("fragment_valid",    LEN_W'(want.frag_valid),
                    LEN_W'(i_result.fragment_valid));
        check_field("fragment_start",    LEN_W'(want.start),
                    LEN_W'(i_result.fragment_start));
        check_field("fragment_length",   want.length, i_result.fragment_length);
        check_field("fragment_overflow", LEN_W'(want.overflow),
                    LEN_W'(i_result.fragment_overflow));
        check_field("last_result",       LEN_W'(want.last),
                    LEN_W'(i_result.last_result));
    endfunction

    // Track register writes and transactions on both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qual_thr  = QUAL_THR_RST;
            low_pct   = LOW_PCT_RST;
            min_len   = MIN_LEN_RST;
            split_sym = SPLIT_SYM_RST;
            clear_read();
            exp_head  = 0;
            exp_tail  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_QUAL_THR:  qual_thr  = i_cfg_data;
                    CFG_LOW_PCT:   low_pct   = i_cfg_data[PCT_W-1:0];
                    CFG_MIN_LEN:   min_len   = i_cfg_data;
                    CFG_SPLIT_SYM: split_sym = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready)
                check_result();
            if (i_base.valid && i_base.ready)
                take_base(i_base.base_char, i_base.quality_char, i_base.end_of_read);
        end
        o_outstanding <= int'(exp_tail - exp_head);
    end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the read quality filter and splitter. Sends short directed
// reads, then short random reads under several register settings (extremes
// among them, with split-dense reads that overflow the fragment table at a
// zero minimum length) with bursty input and a stalling receiver, including
// long receiver hold-offs. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import rqf_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int N_PHASES       = 5;
    localparam int PHASE_BASES    = 35;
    localparam int PHASE_READS    = 5;

    localparam logic [CHAR_W-1:0] CH_A = "A";
    localparam logic [CHAR_W-1:0] CH_C = "C";
    localparam logic [CHAR_W-1:0] CH_G = "G";
    localparam logic [CHAR_W-1:0] CH_T = "T";
    localparam logic [CHAR_W-1:0] CH_N = "N";
    localparam logic [5*CHAR_W-1:0] BASE_SET = {CH_A, CH_C, CH_G, CH_T, CH_N};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rqf_base_if   base_ch ();
    rqf_result_if result_ch ();

    int fail_count, outstanding, reads, fragments, quality_rejects, overflow_reads;

    // Register values in force, used to shape stimulus
    logic [CHAR_W-1:0] cur_thr;
    logic [PCT_W-1:0]  cur_pct;
    logic [CHAR_W-1:0] cur_min;
    logic [CHAR_W-1:0] cur_split;

    int burst_left     = 0;
    int bases_sent     = 0;
    int settings       = 1;
    int holdoff_asked  = 0;
    int holdoff_served = 0;
    int idle_cycles    = 0;

    always #5 clk = ~clk;

    read_quality_filter_n_splitter DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_base     (base_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rqf_tb_checker u_result_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_base            (base_ch),
        .i_result          (result_ch),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_reads           (reads),
        .o_fragments       (fragments),
        .o_quality_rejects (quality_rejects),
        .o_overflow_reads  (overflow_reads)
    );

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (base_ch.valid && base_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one base; idle between bursts of random length
    task automatic send_base(input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] q,
                             input logic eor);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                base_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        base_ch.valid        <= 1'b1;
        base_ch.base_char    <= b;
        base_ch.quality_char <= q;
        base_ch.end_of_read  <= eor;
        @(posedge clk);
        while (!base_ch.ready) @(posedge clk);
        bases_sent++;
    endtask

    task automatic send_text(input string bases, input string quals);
        for (int i = 0; i < bases.len(); i++)
            send_base(bases[i], quals[i], i == bases.len() - 1);
    endtask

    // Send one read of random content shaped by the split and low-quality odds
    task automatic send_read(input int len, input int split_pct, input int lowq,
                             input bit wild);
        int t;
        logic [CHAR_W-1:0] b, q;
        for (int i = 0; i < len; i++) begin
            if (wild && $urandom_range(0, 7) == 0)
                b = CHAR_W'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < split_pct)
                b = cur_split;
            else
                b = BASE_SET[CHAR_W*$urandom_range(1, 4) +: CHAR_W];

            if (wild && $urandom_range(0, 7) == 0) begin
                q = CHAR_W'($urandom_range(0, 255));
            end else if (cur_thr != 0 && $urandom_range(0, 99) < lowq) begin
                t = cur_thr - 1 - ($urandom % ((cur_thr < 10) ? cur_thr : 10));
                q = CHAR_W'(t);
            end else begin
                t = cur_thr + $urandom_range(0, 19);
                q = (t > 255) ? 8'hFF : CHAR_W'(t);
            end
            send_base(b, q, i == len - 1);
        end
    endtask

    // Hold the input until every expected result has arrived, then settle
    task automatic wait_drained();
        base_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic [CHAR_W-1:0] thr, input logic [PCT_W-1:0] pct,
                                 input logic [CHAR_W-1:0] minl,
                                 input logic [CHAR_W-1:0] split);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_QUAL_THR;
        cfg_data <= thr;
        @(posedge clk);
        cfg_idx  <= CFG_LOW_PCT;
        cfg_data <= CFG_DATA_W'(pct);
        @(posedge clk);
        cfg_idx  <= CFG_MIN_LEN;
        cfg_data <= minl;
        @(posedge clk);
        cfg_idx  <= CFG_SPLIT_SYM;
        cfg_data <= split;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_thr   = thr;
        cur_pct   = pct;
        cur_min   = minl;
        cur_split = split;
        settings++;
    endtask

    // Receiver: stall patterns in segments, plus long hold-offs on request
    initial begin
        int seg_left, mode, hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (holdoff_served != holdoff_asked) begin
                holdoff_served++;
                hold_left = HOLDOFF_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= (seg_left % 4 == 0);
                    default: result_ch.ready <= (seg_left % 4 != 0);
                endcase
            end
        end
    end

    // Stimulus
    initial begin
        int phase_start, r, lowq, split_pct;
        bit dense;

        rst_n                <= 1'b0;
        base_ch.valid        <= 1'b0;
        base_ch.base_char    <= '0;
        base_ch.quality_char <= '0;
        base_ch.end_of_read  <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_QUAL_THR;
        cfg_data             <= '0;
        cur_thr   = QUAL_THR_RST;
        cur_pct   = LOW_PCT_RST;
        cur_min   = MIN_LEN_RST;
        cur_split = SPLIT_SYM_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-base reads at the reset settings, field extremes and
        // the quality threshold boundary
        send_base(CH_N, 8'h00, 1'b1);
        send_base(8'hFF, 8'hFF, 1'b1);
        send_base(8'h00, QUAL_THR_RST - 8'd1, 1'b1);
        send_base(CH_A, QUAL_THR_RST, 1'b1);

        // Directed: short fragments, a quality reject, runs cut by the split symbol
        set_registers(QUAL_THR_RST, LOW_PCT_RST, 8'd2, CH_N);
        send_text("AANAAA", "IIIIII");
        send_text("AAN", "I#I");
        send_text("NNAAN", "IIIII");

        // Directed: zero minimum length turns empty runs into fragments
        set_registers(QUAL_THR_RST, LOW_PCT_RST, 8'd0, CH_N);
        send_text("NN", "II");

        // Random reads under several settings. Phases 2 and 3 add a split-dense
        // read, which overflows the table when the minimum length is zero.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: set_registers(8'hFF, 7'd100, 8'hFF, 8'h00);
                1: set_registers(8'h00, 7'd0, 8'd16, 8'hFF);
                2: set_registers(8'd60, 7'd127, 8'd0, CH_N);
                3: set_registers(QUAL_THR_RST, LOW_PCT_RST, 8'($urandom_range(1, 15)), CH_N);
                default: set_registers(8'($urandom_range(40, 80)), 7'($urandom_range(0, 100)),
                                       8'($urandom_range(16, 40)),
                                       BASE_SET[CHAR_W*$urandom_range(0, 4) +: CHAR_W]);
            endcase
            dense = (p == 2 || p == 3);
            // Let the block fill up behind a stalled receiver
            if (p == 1 || p == 3)
                holdoff_asked++;
            phase_start = bases_sent;
            r = 0;
            while (bases_sent - phase_start < PHASE_BASES || r < PHASE_READS) begin
                case ($urandom_range(0, 3))
                    0:       lowq = 0;
                    1:       lowq = 5;
                    2:       lowq = 15;
                    default: lowq = 40;
                endcase
                split_pct = 1 << $urandom_range(0, 5);
                if (dense && r == 2)
                    send_read($urandom_range(18, 20), (cur_min == 0) ? 100 : 90,
                              lowq, 1'b0);
                else if ($urandom_range(0, 4) == 0)
                    send_read($urandom_range(16, 28), split_pct, lowq,
                              $urandom_range(0, 3) == 0);
                else
                    send_read($urandom_range(1, 6), split_pct, lowq,
                              $urandom_range(0, 3) == 0);
                r++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bases in %0d reads, %0d register settings, %0d fragments.",
                 bases_sent, reads, settings, fragments);
        $display("Quality rejects %0d, reads with table overflow %0d, hold-offs %0d.",
                 quality_rejects, overflow_reads, holdoff_served);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rqf_pkg.sv
rtl/rqf_base_if.sv
rtl/rqf_result_if.sv
rtl/rqf_ram.sv
rtl/rqf_front.sv
rtl/rqf_fifo.sv
rtl/rqf_back.sv
rtl/read_quality_filter_n_splitter.sv
rtl/rqf_checker.sv
sim/rqf_checker.sv
sim/tb_top.sv
